FILE: src/tce_pkg.sv
// shared widths, register indexes and reset values of the tricorn escape-time engine
// no dependencies; used by tce_mul and tricorn_escape_time
package tce_pkg;

  // field and arithmetic widths
  localparam int PIXEL_BITS = 10;
  localparam int ITER_BITS  = 10;
  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 32;
  localparam int STEP_BITS  = 31;
  localparam int PROD_BITS  = 2 * COORD_BITS;

  // configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = COORD_BITS;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_RE = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_IM = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PIXEL_STEP = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_ITER = 2'd3;

  // reset values
  localparam logic signed [COORD_BITS-1:0] ORIGIN_RE_RST = -32'sd671088640;
  localparam logic signed [COORD_BITS-1:0] ORIGIN_IM_RST = -32'sd671088640;
  localparam logic [STEP_BITS-1:0]         PIXEL_STEP_RST = 31'd1342177;
  localparam logic [ITER_BITS-1:0]         MAX_ITER_RST = ITER_BITS'(50);

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_BITS  = ((2 * PIXEL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((ITER_BITS + 7) / 8) * 8;

endpackage

FILE: src/tricorn_escape_time.sv
// top level of the tricorn escape-time engine: sequencer, orbit registers, output register
// depends on tce_pkg and tce_mul
//
// One pixel transaction maps (pixel_x, pixel_y) to c = origin + pixel * pixel_step, then
// iterates z = conj(z)^2 + c from z = 0 until |z|^2 > 4 or max_iterations is reached, and
// returns the count (tdata) and the escaped flag (tuser). All products go through a single
// registered 32x32 multiplier: mapping multiplies pixel_x and pixel_y by pixel_step and adds
// the origin, and each iteration runs zr*zr, zi*zi with the escape test, zr*zi, then the
// update. The input is ready only while the sequencer is idle. A finished result sits in an
// output register, so the next pixel can be accepted while it waits.
module tricorn_escape_time
  import tce_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration writes
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  // pixel input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // pixel_x, pixel_y, zero pad
  // result output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,  // iteration_count, zero pad
  output logic                      m_axis_tuser   // escaped
);

  localparam int SQ_BITS   = PROD_BITS - FRAC_BITS;
  localparam int MAG_BITS  = SQ_BITS + 1;
  localparam int WIDE_BITS = PROD_BITS + 1;
  localparam logic signed [MAG_BITS-1:0] ESC_LIMIT = MAG_BITS'(64'sd4 <<< FRAC_BITS);
  localparam logic signed [WIDE_BITS-1:0] COORD_MAX =
    WIDE_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [WIDE_BITS-1:0] COORD_MIN =
    -COORD_MAX - WIDE_BITS'(1);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MAP_RE  = 4'd1;
  localparam logic [3:0] ST_MAP_IM  = 4'd2;
  localparam logic [3:0] ST_MAP_END = 4'd3;
  localparam logic [3:0] ST_SQR_RE  = 4'd4;
  localparam logic [3:0] ST_SQR_IM  = 4'd5;
  localparam logic [3:0] ST_CROSS   = 4'd6;
  localparam logic [3:0] ST_UPDATE  = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_BITS-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [COORD_BITS-1:0] origin_re_q, origin_im_q;
  logic [STEP_BITS-1:0]         pixel_step_q;
  logic [ITER_BITS-1:0]         max_iter_q;

  // datapath registers
  logic [3:0]                   state_q, state_d;
  logic [PIXEL_BITS-1:0]        px_q, py_q;
  logic signed [COORD_BITS-1:0] c_re_q, c_im_q, zr_q, zi_q;
  logic signed [SQ_BITS-1:0]    sr_q;
  logic [ITER_BITS-1:0]         iter_q;
  logic                         esc_q;
  logic                         out_valid_q;
  logic [ITER_BITS-1:0]         out_count_q;
  logic                         out_esc_q;

  // multiplier connections
  logic signed [COORD_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0]  mul_p;
  logic signed [SQ_BITS-1:0]    prod_fx;
  logic signed [MAG_BITS-1:0]   mag;
  logic                         escape_now;
  logic                         stop_now;
  logic signed [WIDE_BITS-1:0]  map_sum_re, map_sum_im;
  logic signed [COORD_BITS-1:0] zr_next, zi_next;
  logic                         in_fire;
  logic                         out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MAP_RE: begin
        mul_a = COORD_BITS'(px_q);
        mul_b = COORD_BITS'(pixel_step_q);
      end
      ST_MAP_IM: begin
        mul_a = COORD_BITS'(py_q);
        mul_b = COORD_BITS'(pixel_step_q);
      end
      ST_SQR_RE: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      ST_SQR_IM: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      ST_CROSS: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tce_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // product scaled back to fixed point, rounding toward minus infinity
  assign prod_fx = $signed(mul_p[PROD_BITS-1:FRAC_BITS]);

  // escape test, valid in the cross state where the product is zi*zi
  assign mag        = MAG_BITS'(sr_q) + MAG_BITS'(prod_fx);
  assign escape_now = (mag > ESC_LIMIT);
  assign stop_now   = escape_now || (iter_q >= max_iter_q);

  // point mapping
  assign map_sum_re = WIDE_BITS'(origin_re_q) + WIDE_BITS'(mul_p);
  assign map_sum_im = WIDE_BITS'(origin_im_q) + WIDE_BITS'(mul_p);

  // orbit update, valid in the update state where the product is zr*zi
  logic signed [SQ_BITS-1:0] si_q;
  assign zr_next = sat_coord(WIDE_BITS'(sr_q) - WIDE_BITS'(si_q) + WIDE_BITS'(c_re_q));
  assign zi_next = sat_coord(WIDE_BITS'(c_im_q) - (WIDE_BITS'(prod_fx) <<< 1));

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_fire) state_d = ST_MAP_RE;
      ST_MAP_RE:  state_d = ST_MAP_IM;
      ST_MAP_IM:  state_d = ST_MAP_END;
      ST_MAP_END: state_d = ST_SQR_RE;
      ST_SQR_RE:  state_d = ST_SQR_IM;
      ST_SQR_IM:  state_d = ST_CROSS;
      ST_CROSS:   state_d = stop_now ? ST_DONE : ST_UPDATE;
      ST_UPDATE:  state_d = ST_SQR_RE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q  <= ORIGIN_RE_RST;
      origin_im_q  <= ORIGIN_IM_RST;
      pixel_step_q <= PIXEL_STEP_RST;
      max_iter_q   <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ORIGIN_RE:  origin_re_q  <= cfg_data_i;
        REG_ORIGIN_IM:  origin_im_q  <= cfg_data_i;
        REG_PIXEL_STEP: pixel_step_q <= cfg_data_i[STEP_BITS-1:0];
        REG_MAX_ITER:   max_iter_q   <= cfg_data_i[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          px_q <= s_axis_tdata[PIXEL_BITS-1:0];
          py_q <= s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
        end
      end
      ST_MAP_IM:  c_re_q <= sat_coord(map_sum_re);
      ST_MAP_END: begin
        c_im_q <= sat_coord(map_sum_im);
        zr_q   <= '0;
        zi_q   <= '0;
        iter_q <= '0;
      end
      ST_SQR_IM:  sr_q <= prod_fx;
      ST_CROSS: begin
        si_q  <= prod_fx;
        esc_q <= escape_now;
      end
      ST_UPDATE: begin
        zr_q   <= zr_next;
        zi_q   <= zi_next;
        iter_q <= iter_q + ITER_BITS'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_count_q <= iter_q;
          out_esc_q   <= esc_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_BITS'(out_count_q);
  assign m_axis_tuser  = out_esc_q;

endmodule

FILE: src/tce_mul.sv
// shared signed 32x32 multiplier with a registered product
// depends on tce_pkg
module tce_mul
  import tce_pkg::*;
(
  input  logic                          clk_i,
  input  logic signed [COORD_BITS-1:0]  a_i,
  input  logic signed [COORD_BITS-1:0]  b_i,
  output logic signed [PROD_BITS-1:0]   p_o
);

  logic signed [PROD_BITS-1:0] p_q;
  logic signed [PROD_BITS-1:0] p_d;

  // full-width product
  assign p_d = PROD_BITS'(a_i) * PROD_BITS'(b_i);

  // product register
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
